// File: rtl/bir_pkg.sv
// Shared constants and types for the bilinear image resizer.
`default_nettype none

package bir_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 4;
	localparam int POS_W      = 8;
	localparam int SIZE_W     = 9;
	localparam int STEP_W     = 24;
	localparam int SRC_W      = POS_W + STEP_W;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;
	localparam logic [CH_W-1:0] CH_ZERO = 8'd0;

	typedef logic [CH_W-1:0] chan_t;
	typedef chan_t [NUM_CH-1:0] pix_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH,
		REG_SOURCE_HEIGHT,
		REG_STEP_X,
		REG_STEP_Y
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/bir_if.sv
// Channel interfaces: request items, result pixels and register writes.
`default_nettype none

interface bir_req_if;
	logic                        valid;
	logic                        ready;
	bir_pkg::op_t                op;
	logic [bir_pkg::POS_W-1:0]   pos_x;
	logic [bir_pkg::POS_W-1:0]   pos_y;
	bir_pkg::chan_t              in_red;
	bir_pkg::chan_t              in_green;
	bir_pkg::chan_t              in_blue;
	bir_pkg::chan_t              in_alpha;

	modport source (output valid, op, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
		input ready);
	modport sink (input valid, op, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
		output ready);
endinterface

interface bir_rsp_if;
	logic           valid;
	logic           ready;
	bir_pkg::chan_t out_red;
	bir_pkg::chan_t out_green;
	bir_pkg::chan_t out_blue;
	bir_pkg::chan_t out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface bir_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bir_pkg::CFG_IDX_W-1:0]    index;
	logic [bir_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/bilinear_image_resizer.sv
// Bilinear RGBA8 scaler: banked source store and seven-stage interpolation pipeline.
//
//  channel | dir | payload                                   | transaction
//  req     | in  | op, pos_x, pos_y, in_red..in_alpha        | load pixel or sample request
//  rsp     | out | out_red, out_green, out_blue, out_alpha   | one pixel per sample
//  cfg     | in  | index, data                               | register write, always ready
//
// One item per cycle sustained while rsp is ready; a sample result leaves from the stage 7 output register.
// The store is four banks split by row and column parity, each with one write and
// one read port, so the four neighbors of a sample are fetched together in stage 3.
// Loads write in the memory stage (stage 3) in request order and then leave the pipe.
// Reset clears the configuration registers and valid bits; store contents stay undefined until loaded.
// Each stage holds while the next one is full and stalled; bubbles are squeezed out.
`default_nettype none

module bilinear_image_resizer #(
	parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = bir_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bir_req_if.sink    req,
	bir_rsp_if.source  rsp,
	bir_cfg_if.sink    cfg
);

	localparam int F     = FRAC_BITS;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int HW    = (MAX_WIDTH + 1) / 2;
	localparam int HH    = (MAX_HEIGHT + 1) / 2;
	localparam int BD    = HW * HH;
	localparam int BAW   = (BD > 1) ? $clog2(BD) : 1;
	localparam int PT_W  = F + 10;
	localparam int VP_W  = 2 * F + 11;
	localparam int NCH   = bir_pkg::NUM_CH;
	localparam int SRC_W = bir_pkg::SRC_W;

	localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);
	localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);
	localparam logic signed [VP_W-1:0] RND = VP_W'(1) << (2 * F - 1);

	function automatic logic [BAW-1:0] bank_addr(input logic [31:0] col, input logic [31:0] row);
		logic [31:0] lin;
		lin = (row >> 1) * 32'(HW) + (col >> 1);
		return lin[BAW-1:0];
	endfunction

	// configuration registers
	logic [bir_pkg::SIZE_W-1:0] source_width_q;
	logic [bir_pkg::SIZE_W-1:0] source_height_q;
	logic [bir_pkg::STEP_W-1:0] step_x_q;
	logic [bir_pkg::STEP_W-1:0] step_y_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= '0;
			source_height_q <= '0;
			step_x_q        <= '0;
			step_y_q        <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				bir_pkg::REG_SOURCE_WIDTH: begin
					source_width_q <= cfg.data[bir_pkg::SIZE_W-1:0];
				end
				bir_pkg::REG_SOURCE_HEIGHT: begin
					source_height_q <= cfg.data[bir_pkg::SIZE_W-1:0];
				end
				bir_pkg::REG_STEP_X: begin
					step_x_q <= cfg.data[bir_pkg::STEP_W-1:0];
				end
				bir_pkg::REG_STEP_Y: begin
					step_y_q <= cfg.data[bir_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage valids and enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	assign en_s7 = !vld_s7 || rsp.ready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign req.ready = en_s1;

	logic smp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= req.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2 && smp_s2;  // loads retire in the memory stage
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// stage 1: capture and scale coordinates
	bir_pkg::op_t              op_s1;
	logic [bir_pkg::POS_W-1:0] px_s1, py_s1;
	bir_pkg::pix_t             pix_s1;
	logic [SRC_W-1:0]          srcx_s1, srcy_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1   <= req.op;
			px_s1   <= req.pos_x;
			py_s1   <= req.pos_y;
			pix_s1  <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
			srcx_s1 <= SRC_W'(req.pos_x) * SRC_W'(step_x_q);
			srcy_s1 <= SRC_W'(req.pos_y) * SRC_W'(step_y_q);
		end
	end

	// stage 2: clamp to the source, pick neighbor columns/rows, form bank addresses
	logic [CW-1:0] last_x, x0, x1;
	logic [RW-1:0] last_y, y0, y1;
	logic [CW-1:0] col_sel [2];
	logic [RW-1:0] row_sel [2];
	logic          empty;
	logic          in_store;

	always_comb begin
		empty = (source_width_q == '0) || (source_height_q == '0);

		if (source_width_q == '0)
			last_x = '0;
		else if (32'(source_width_q) > 32'(MAX_WIDTH))
			last_x = LAST_COL;
		else
			last_x = CW'(source_width_q - bir_pkg::SIZE_W'(1));

		if (source_height_q == '0)
			last_y = '0;
		else if (32'(source_height_q) > 32'(MAX_HEIGHT))
			last_y = LAST_ROW;
		else
			last_y = RW'(source_height_q - bir_pkg::SIZE_W'(1));

		x0 = (32'(srcx_s1 >> F) > 32'(last_x)) ? last_x : CW'(srcx_s1 >> F);
		y0 = (32'(srcy_s1 >> F) > 32'(last_y)) ? last_y : RW'(srcy_s1 >> F);
		x1 = (x0 == last_x) ? x0 : x0 + CW'(1);
		y1 = (y0 == last_y) ? y0 : y0 + RW'(1);

		// each parity bank serves whichever neighbor has its parity
		for (int i = 0; i < 2; i++) begin
			col_sel[i] = (x0[0] == i[0]) ? x0 : x1;
			row_sel[i] = (y0[0] == i[0]) ? y0 : y1;
		end

		in_store = (32'(px_s1) < 32'(MAX_WIDTH)) && (32'(py_s1) < 32'(MAX_HEIGHT));
	end

	logic             empty_s2;
	logic             wr_en_s2;
	logic             wr_row_s2, wr_col_s2;
	logic [BAW-1:0]   wr_addr_s2;
	bir_pkg::pix_t    pix_s2;
	logic [BAW-1:0]   rd_addr_s2 [2][2];
	logic             x0p_s2, x1p_s2, y0p_s2, y1p_s2;
	logic [F-1:0]     fx_s2, fy_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			smp_s2     <= (op_s1 == bir_pkg::OP_SAMPLE);
			empty_s2   <= empty;
			wr_en_s2   <= (op_s1 == bir_pkg::OP_LOAD) && in_store;
			wr_row_s2  <= py_s1[0];
			wr_col_s2  <= px_s1[0];
			wr_addr_s2 <= bank_addr(32'(px_s1), 32'(py_s1));
			pix_s2     <= pix_s1;
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 2; c++) begin
					rd_addr_s2[r][c] <= bank_addr(32'(col_sel[c]), 32'(row_sel[r]));
				end
			end
			x0p_s2 <= x0[0];
			x1p_s2 <= x1[0];
			y0p_s2 <= y0[0];
			y1p_s2 <= y1[0];
			fx_s2  <= srcx_s1[F-1:0];
			fy_s2  <= srcy_s1[F-1:0];
		end
	end

	// stage 3: banked store, one write or four reads per item
	bir_pkg::pix_t bank_rd [2][2];

	for (genvar pr = 0; pr < 2; pr++) begin : g_row
		for (genvar pc = 0; pc < 2; pc++) begin : g_col
			bir_pkg::pix_t store_q [BD];
			bir_pkg::pix_t rd_s3;

			always_ff @(posedge clk) begin
				if (en_s3 && vld_s2 && wr_en_s2 && wr_row_s2 == 1'(pr) && wr_col_s2 == 1'(pc))
					store_q[wr_addr_s2] <= pix_s2;
				if (en_s3)
					rd_s3 <= store_q[rd_addr_s2[pr][pc]];
			end

			assign bank_rd[pr][pc] = rd_s3;
		end
	end

	logic         empty_s3;
	logic         x0p_s3, x1p_s3, y0p_s3, y1p_s3;
	logic [F-1:0] fx_s3, fy_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			empty_s3 <= empty_s2;
			x0p_s3   <= x0p_s2;
			x1p_s3   <= x1p_s2;
			y0p_s3   <= y0p_s2;
			y1p_s3   <= y1p_s2;
			fx_s3    <= fx_s2;
			fy_s3    <= fy_s2;
		end
	end

	// stage 4: horizontal deltas times fx
	bir_pkg::pix_t          p00, p10, p01, p11;
	logic signed [8:0]      dt [NCH];
	logic signed [8:0]      db [NCH];
	logic signed [PT_W-1:0] pt [NCH];
	logic signed [PT_W-1:0] pb [NCH];
	logic signed [F:0]      fxs;

	always_comb begin
		p00 = bank_rd[y0p_s3][x0p_s3];
		p10 = bank_rd[y0p_s3][x1p_s3];
		p01 = bank_rd[y1p_s3][x0p_s3];
		p11 = bank_rd[y1p_s3][x1p_s3];
		fxs = $signed({1'b0, fx_s3});
		for (int c = 0; c < NCH; c++) begin
			dt[c] = $signed({1'b0, p10[c]}) - $signed({1'b0, p00[c]});
			db[c] = $signed({1'b0, p11[c]}) - $signed({1'b0, p01[c]});
			pt[c] = dt[c] * fxs;
			pb[c] = db[c] * fxs;
		end
	end

	bir_pkg::pix_t          a_s4, l_s4;
	logic signed [PT_W-1:0] pt_s4 [NCH];
	logic signed [PT_W-1:0] pb_s4 [NCH];
	logic [F-1:0]           fy_s4;
	logic                   empty_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			a_s4     <= p00;
			l_s4     <= p01;
			pt_s4    <= pt;
			pb_s4    <= pb;
			fy_s4    <= fy_s3;
			empty_s4 <= empty_s3;
		end
	end

	// stage 5: top row value and bottom-minus-top difference
	logic signed [8:0]      dv  [NCH];
	logic signed [PT_W-1:0] top [NCH];
	logic signed [PT_W-1:0] vd  [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			dv[c]  = $signed({1'b0, l_s4[c]}) - $signed({1'b0, a_s4[c]});
			top[c] = $signed({2'b00, a_s4[c], {F{1'b0}}}) + pt_s4[c];
			vd[c]  = $signed({dv[c][8], dv[c], {F{1'b0}}}) + pb_s4[c] - pt_s4[c];
		end
	end

	logic [F+7:0]           top_s5 [NCH];
	logic signed [PT_W-1:0] vd_s5  [NCH];
	logic [F-1:0]           fy_s5;
	logic                   empty_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int c = 0; c < NCH; c++) begin
				top_s5[c] <= top[c][F+7:0];
			end
			vd_s5    <= vd;
			fy_s5    <= fy_s4;
			empty_s5 <= empty_s4;
		end
	end

	// stage 6: vertical difference times fy
	logic signed [VP_W-1:0] vp [NCH];
	logic signed [F:0]      fys;

	always_comb begin
		fys = $signed({1'b0, fy_s5});
		for (int c = 0; c < NCH; c++) begin
			vp[c] = vd_s5[c] * fys;
		end
	end

	logic [F+7:0]           top_s6 [NCH];
	logic signed [VP_W-1:0] vp_s6  [NCH];
	logic                   empty_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			top_s6   <= top_s5;
			vp_s6    <= vp;
			empty_s6 <= empty_s5;
		end
	end

	// stage 7: final sum, round half up, saturate, zero for an empty source; output register
	logic signed [VP_W-1:0] sum [NCH];
	logic [8:0]             rnd [NCH];
	bir_pkg::pix_t          res;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			sum[c] = $signed({3'b000, top_s6[c], {F{1'b0}}}) + vp_s6[c] + RND;
			rnd[c] = sum[c][2*F+8:2*F];
			if (empty_s6)
				res[c] = bir_pkg::CH_ZERO;
			else if (rnd[c] > {1'b0, bir_pkg::CH_MAX})
				res[c] = bir_pkg::CH_MAX;
			else
				res[c] = rnd[c][7:0];
		end
	end

	bir_pkg::pix_t out_s7;

	always_ff @(posedge clk) begin
		if (en_s7) out_s7 <= res;
	end

	assign rsp.valid     = vld_s7;
	assign rsp.out_red   = out_s7[0];
	assign rsp.out_green = out_s7[1];
	assign rsp.out_blue  = out_s7[2];
	assign rsp.out_alpha = out_s7[3];

endmodule

`default_nettype wire
